// ===== src/mhpq_pkg.sv =====
// Shared types and constants for the max-heap priority queue.
// No dependencies; used by the engine and the top level.
package mhpq_pkg;

  localparam int KEY_W        = 32;
  localparam int COUNT_W      = 8;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 255;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] max_key;
    logic [COUNT_W-1:0]      count;
  } res_t;

endpackage

// ===== src/max_heap_priority_queue.sv =====
// Max-heap priority queue over one RAM of CAPACITY+1 words.
// Depends on mhpq_pkg, mhpq_engine and mhpq_ram.
// An insert places its key at the new leaf and climbs while it is greater than its parent; a
// remove returns the root, moves the last element to the top and sifts it down past larger
// children. The engine works on one item at a time; the next input is taken from the cycle in
// which the previous result turns valid at the output. Reset empties the heap.
module max_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic signed [mhpq_pkg::KEY_W-1:0]    in_key,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mhpq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [mhpq_pkg::KEY_W-1:0]    out_max_key,
  output logic [mhpq_pkg::COUNT_W-1:0]         out_count
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY + 1);

  logic          eng_idle;
  logic          res_valid;
  logic          res_take;
  res_t          eng_res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  logic          out_valid_r, out_valid_nxt;
  res_t          out_res_r, out_res_nxt;

  assign in_ready = eng_idle;
  // hand a finished result over once the output slot is free or draining
  assign res_take = res_valid && (!out_valid_r || out_ready);

  mhpq_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && in_ready),
    .action    (in_action),
    .key       (in_key),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (eng_res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  mhpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY + 1)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = eng_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_res_r.status;
  assign out_max_key = out_res_r.max_key;
  assign out_count   = out_res_r.count;

endmodule

// ===== src/mhpq_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/mhpq_engine.sv =====
// Heap sequencer: runs sift-up and sift-down against the heap RAM, with no cycle
// both reading and writing it. Depends on mhpq_pkg.
module mhpq_engine #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                action,
  input  logic signed [mhpq_pkg::KEY_W-1:0]   key,
  output logic                                idle,
  output logic                                res_valid,
  input  logic                                res_take,
  output mhpq_pkg::res_t                      res,
  output logic                                ram_we,
  output logic [$clog2(CAPACITY+1)-1:0]       ram_waddr,
  output logic [mhpq_pkg::KEY_W-1:0]          ram_wdata,
  output logic                                ram_re,
  output logic [$clog2(CAPACITY+1)-1:0]       ram_raddr,
  input  logic [mhpq_pkg::KEY_W-1:0]          ram_rdata
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] CAP = AW'(CAPACITY);
  localparam logic [AW-1:0] ONE = AW'(1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP_RD    = 4'd1;
  localparam logic [3:0] S_UP_CMP   = 4'd2;
  localparam logic [3:0] S_DN_TOP   = 4'd3;
  localparam logic [3:0] S_DN_MOVE  = 4'd4;
  localparam logic [3:0] S_DN_KID   = 4'd5;
  localparam logic [3:0] S_DN_LEFT  = 4'd6;
  localparam logic [3:0] S_DN_RIGHT = 4'd7;
  localparam logic [3:0] S_DN_CMP   = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;

  logic [3:0]              state_r, state_nxt;
  logic [AW-1:0]           cnt_r, cnt_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic [AW:0]             kid_r, kid_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] top_r, top_nxt;
  logic signed [KEY_W-1:0] big_r, big_nxt;
  res_t                    res_r, res_nxt;
  logic signed [KEY_W-1:0] rd_key;

  assign rd_key    = $signed(ram_rdata);
  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res       = res_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    kid_nxt   = kid_r;
    key_nxt   = key_r;
    top_nxt   = top_r;
    big_nxt   = big_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = key_r;
    ram_re    = 1'b0;
    ram_raddr = ONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt = key;
          if (action == ACT_INSERT) begin
            if (cnt_r >= CAP) begin
              res_nxt   = '{STATUS_FULL, '0, COUNT_W'(cnt_r)};
              state_nxt = S_FIN;
            end else begin
              pos_nxt   = cnt_r + ONE;
              cnt_nxt   = cnt_r + ONE;
              state_nxt = S_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              res_nxt   = '{STATUS_EMPTY, '0, COUNT_W'(cnt_r)};
              state_nxt = S_FIN;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = ONE;
              state_nxt = S_DN_TOP;
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == ONE) begin
          ram_we    = 1'b1;
          res_nxt   = '{STATUS_DONE, '0, COUNT_W'(cnt_r)};
          state_nxt = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = pos_r >> 1;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (key_r > rd_key) begin
          // move the smaller parent down into the hole
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r >> 1;
          state_nxt = S_UP_RD;
        end else begin
          res_nxt   = '{STATUS_DONE, '0, COUNT_W'(cnt_r)};
          state_nxt = S_FIN;
        end
      end
      S_DN_TOP: begin
        top_nxt   = rd_key;
        ram_re    = 1'b1;
        ram_raddr = cnt_r;
        state_nxt = S_DN_MOVE;
      end
      S_DN_MOVE: begin
        key_nxt   = rd_key;
        cnt_nxt   = cnt_r - ONE;
        pos_nxt   = ONE;
        kid_nxt   = (AW+1)'(2);
        state_nxt = S_DN_KID;
      end
      S_DN_KID: begin
        if (kid_r > {1'b0, cnt_r}) begin
          ram_we    = 1'b1;
          res_nxt   = '{STATUS_DONE, top_r, COUNT_W'(cnt_r)};
          state_nxt = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = kid_r[AW-1:0];
          state_nxt = S_DN_LEFT;
        end
      end
      S_DN_LEFT: begin
        big_nxt = rd_key;
        if (kid_r < {1'b0, cnt_r}) begin
          ram_re    = 1'b1;
          ram_raddr = kid_r[AW-1:0] + ONE;
          state_nxt = S_DN_RIGHT;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_RIGHT: begin
        // left child wins ties
        if (rd_key > big_r) begin
          big_nxt = rd_key;
          kid_nxt = kid_r + (AW+1)'(1);
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (big_r > key_r) begin
          ram_wdata = big_r;
          pos_nxt   = kid_r[AW-1:0];
          kid_nxt   = {kid_r[AW-1:0], 1'b0};
          state_nxt = S_DN_KID;
        end else begin
          res_nxt   = '{STATUS_DONE, top_r, COUNT_W'(cnt_r)};
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    pos_r <= pos_nxt;
    kid_r <= kid_nxt;
    key_r <= key_nxt;
    top_r <= top_nxt;
    big_r <= big_nxt;
    res_r <= res_nxt;
  end

endmodule
